// ===== rtl/core/hsl2rgb_pkg.sv =====
// ============================================================================
// HSL to RGB converter package
// Shared widths, fixed-point constants, the percent-to-level table and the
// hue segment decoder used by the converter pipeline.
// ============================================================================
package hsl2rgb_pkg;

   // Fraction bits of the unsigned fixed-point working format.
   localparam int FRAC_BITS = 16;
   localparam int FX_W      = FRAC_BITS + 1;   // holds 0 .. 1.0 inclusive

   localparam int HUE_W  = 9;
   localparam int PCT_W  = 7;
   localparam int BYTE_W = 8;
   localparam int DEG_W  = 9;
   localparam int K_W    = 6;                  // ramp position, 0 .. 60 degrees

   localparam int IN_DATA_W  = 24;
   localparam int OUT_DATA_W = 24;

   // Seven register stages from the input transaction to the output register.
   localparam int PIPE_DEPTH = 7;

   localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
   localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;
   localparam int PCT_LEVELS = 101;

   localparam logic [DEG_W-1:0] DEG_60  = 9'd60;
   localparam logic [DEG_W-1:0] DEG_120 = 9'd120;
   localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
   localparam logic [DEG_W-1:0] DEG_240 = 9'd240;

   typedef logic [FX_W-1:0] fx_type;

   localparam fx_type ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

   // Division of the ramp product by 60 is done as a shift by two followed by
   // a reciprocal multiply by 1/15 with a single correction step.
   localparam int RAMP_DIV     = 15;
   localparam int Y_W          = FRAC_BITS + 4;
   localparam int X_W          = FX_W + K_W;
   localparam int RECIP_SHIFT  = Y_W;
   localparam int T_W          = Y_W + FX_W;
   localparam fx_type RECIP_15 = FX_W'((64'(1) << RECIP_SHIFT) / 64'(RAMP_DIV));

   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_HIGH,
      SEG_FALL,
      SEG_LOW
   } seg_type;

   typedef struct packed {
      seg_type        seg;
      logic [K_W-1:0] k;
   } ramp_ctl_type;

   typedef fx_type level_table_type [0:PCT_LEVELS-1];

   function automatic level_table_type build_level_table();
      level_table_type t;
      for (int i = 0; i < PCT_LEVELS; i++) begin
         t[i] = FX_W'((64'(i) << FRAC_BITS) / 64'(PCT_MAX));
      end
      return t;
   endfunction

   // Percent to fixed-point level, floor(pct * 2^FRAC_BITS / 100).
   localparam level_table_type LEVEL_TABLE = build_level_table();

   // Decodes a hue position in degrees into its ramp segment and the
   // distance into the rising or falling edge.
   function automatic ramp_ctl_type ramp_ctl(input logic [DEG_W-1:0] deg);
      ramp_ctl_type   c;
      logic [DEG_W-1:0] fall;
      fall = DEG_240 - deg;
      if (deg < DEG_60) begin
         c.seg = SEG_RISE;
         c.k   = deg[K_W-1:0];
      end else if (deg < DEG_180) begin
         c.seg = SEG_HIGH;
         c.k   = '0;
      end else if (deg < DEG_240) begin
         c.seg = SEG_FALL;
         c.k   = fall[K_W-1:0];
      end else begin
         c.seg = SEG_LOW;
         c.k   = '0;
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/hsl2rgb_channel.sv =====
// ============================================================================
// HSL to RGB colour channel
// Evaluates the hue ramp for one colour channel and scales the level to a
// byte, over four register stages that advance on a shared enable.
// ============================================================================
module hsl2rgb_channel import hsl2rgb_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  fx_type            p,
   input  fx_type            q,
   input  fx_type            d,
   input  ramp_ctl_type      ctl,
   output logic [BYTE_W-1:0] chan_byte
);

   // Stage 1: ramp product d * k.
   logic [X_W-1:0] c1_x_ff,  c1_x_in;
   fx_type         c1_p_ff,  c1_q_ff;
   seg_type        c1_seg_ff;

   // Stage 2: reciprocal multiply.
   logic [T_W-1:0] c2_t_ff,  c2_t_in;
   logic [Y_W-1:0] c2_y_ff,  c2_y_in;
   fx_type         c2_p_ff,  c2_q_ff;
   seg_type        c2_seg_ff;

   // Stage 3: corrected quotient and channel level.
   fx_type         c3_v_ff,  c3_v_in;

   // Stage 4: output byte.
   logic [BYTE_W-1:0] c4_byte_ff, c4_byte_in;

   fx_type         qt_est;
   fx_type         quot;
   logic [Y_W:0]   qt15;
   logic [Y_W:0]   rem;
   logic [FX_W+BYTE_W-1:0] v255;
   logic [BYTE_W:0]        scaled;

   always_comb begin
      c1_x_in = X_W'(d) * X_W'(ctl.k);
   end

   always_comb begin
      c2_y_in = c1_x_ff[2 +: Y_W];
      c2_t_in = T_W'(c2_y_in) * T_W'(RECIP_15);
   end

   // The estimate is at most one below the true quotient.
   always_comb begin
      qt_est = c2_t_ff[RECIP_SHIFT +: FX_W];
      qt15   = {qt_est, 4'b0000} - (Y_W+1)'(qt_est);
      rem    = (Y_W+1)'(c2_y_ff) - qt15;
      if (rem >= (Y_W+1)'(RAMP_DIV)) begin
         quot = qt_est + FX_W'(1);
      end else begin
         quot = qt_est;
      end
      case (c2_seg_ff)
         SEG_RISE: c3_v_in = c2_p_ff + quot;
         SEG_FALL: c3_v_in = c2_p_ff + quot;
         SEG_HIGH: c3_v_in = c2_q_ff;
         SEG_LOW:  c3_v_in = c2_p_ff;
         default:  c3_v_in = c2_p_ff;
      endcase
   end

   always_comb begin
      v255   = {c3_v_ff, {BYTE_W{1'b0}}} - (FX_W+BYTE_W)'(c3_v_ff);
      scaled = v255[FRAC_BITS +: BYTE_W+1];
      if (scaled[BYTE_W]) begin
         c4_byte_in = {BYTE_W{1'b1}};
      end else begin
         c4_byte_in = scaled[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_x_ff    <= c1_x_in;
         c1_p_ff    <= p;
         c1_q_ff    <= q;
         c1_seg_ff  <= ctl.seg;
         c2_t_ff    <= c2_t_in;
         c2_y_ff    <= c2_y_in;
         c2_p_ff    <= c1_p_ff;
         c2_q_ff    <= c1_q_ff;
         c2_seg_ff  <= c1_seg_ff;
         c3_v_ff    <= c3_v_in;
         c4_byte_ff <= c4_byte_in;
      end
   end

   assign chan_byte = c4_byte_ff;

endmodule

// ===== rtl/core/hsl_to_rgb_converter.sv =====
// ============================================================================
// HSL to RGB converter
// Converts one HSL colour per transaction into an 8-bit-per-channel RGB
// colour in unsigned fixed point.
// ============================================================================
// The converter takes one colour every clock cycle as long as the result side
// keeps up. It has seven register stages around the multipliers: level lookup,
// lightness-saturation product, q/p formation, then per channel the ramp
// product, the reciprocal multiply for the divide by sixty, the quotient
// correction and the byte scaling. When the result side stalls the whole
// pipeline holds and the input side is held off; nothing is dropped.
// Hue above 360 and saturation or lightness above 100 are clamped.
module hsl_to_rgb_converter import hsl2rgb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [8:0] hue, [15:9] saturation, [22:16] lightness, [23] zero
   input  logic [IN_DATA_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue
   output logic [OUT_DATA_W-1:0] rsp_tdata
);

   logic adv;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;

   logic [HUE_W-1:0] hue_in;
   logic [PCT_W-1:0] sat_in, lig_in;
   logic [HUE_W-1:0] hue_c;
   logic [PCT_W-1:0] sat_c, lig_c;
   logic [DEG_W-1:0] deg_r, deg_b;

   // Stage 1
   fx_type       s1_l_ff, s1_s_ff;
   logic         s1_low_ff;
   ramp_ctl_type s1_ctl_ff [0:2];
   ramp_ctl_type ctl_in    [0:2];

   // Stage 2
   fx_type       s2_l_ff, s2_s_ff, s2_ls_ff, s2_ls_in;
   logic         s2_low_ff;
   ramp_ctl_type s2_ctl_ff [0:2];
   logic [2*FX_W-1:0] ls_prod;

   // Stage 3
   fx_type       s3_p_ff, s3_q_ff, s3_d_ff;
   fx_type       s3_p_in, s3_q_in, s3_d_in;
   ramp_ctl_type s3_ctl_ff [0:2];
   logic [FX_W:0] q_sum, two_l, p_raw;

   logic [BYTE_W-1:0] red, green, blue;

   // The pipeline moves whenever the output register is empty or being taken.
   assign adv        = rsp_tready || !valid_ff[PIPE_DEPTH-1];
   assign req_tready = adv;
   assign valid_in   = {valid_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      hue_in = req_tdata[8:0];
      sat_in = req_tdata[15:9];
      lig_in = req_tdata[22:16];
      hue_c  = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
      sat_c  = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
      lig_c  = (lig_in > PCT_MAX) ? PCT_MAX : lig_in;
      deg_r  = (hue_c + DEG_120 > HUE_MAX) ? (hue_c - DEG_240) : (hue_c + DEG_120);
      deg_b  = (hue_c >= DEG_120) ? (hue_c - DEG_120) : (hue_c + DEG_240);
      ctl_in[0] = ramp_ctl(deg_r);
      ctl_in[1] = ramp_ctl(hue_c);
      ctl_in[2] = ramp_ctl(deg_b);
   end

   always_comb begin
      ls_prod  = (2*FX_W)'(s1_l_ff) * (2*FX_W)'(s1_s_ff);
      s2_ls_in = ls_prod[FRAC_BITS +: FX_W];
   end

   // Zero saturation needs no special case: q and p both collapse to l.
   always_comb begin
      if (s2_low_ff) begin
         q_sum = (FX_W+1)'(s2_l_ff) + (FX_W+1)'(s2_ls_ff);
      end else begin
         q_sum = (FX_W+1)'(s2_l_ff) + (FX_W+1)'(s2_s_ff) - (FX_W+1)'(s2_ls_ff);
      end
      if (q_sum > (FX_W+1)'(ONE_FX)) begin
         s3_q_in = ONE_FX;
      end else begin
         s3_q_in = q_sum[FX_W-1:0];
      end
      two_l = {s2_l_ff, 1'b0};
      if (two_l >= (FX_W+1)'(s3_q_in)) begin
         p_raw = two_l - (FX_W+1)'(s3_q_in);
      end else begin
         p_raw = '0;
      end
      if (p_raw > (FX_W+1)'(s3_q_in)) begin
         s3_p_in = s3_q_in;
      end else begin
         s3_p_in = p_raw[FX_W-1:0];
      end
      s3_d_in = s3_q_in - s3_p_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_l_ff   <= LEVEL_TABLE[lig_c];
         s1_s_ff   <= LEVEL_TABLE[sat_c];
         s1_low_ff <= (lig_c < PCT_HALF);
         s2_l_ff   <= s1_l_ff;
         s2_s_ff   <= s1_s_ff;
         s2_ls_ff  <= s2_ls_in;
         s2_low_ff <= s1_low_ff;
         s3_p_ff   <= s3_p_in;
         s3_q_ff   <= s3_q_in;
         s3_d_ff   <= s3_d_in;
         for (int i = 0; i < 3; i++) begin
            s1_ctl_ff[i] <= ctl_in[i];
            s2_ctl_ff[i] <= s1_ctl_ff[i];
            s3_ctl_ff[i] <= s2_ctl_ff[i];
         end
      end
   end

   hsl2rgb_channel u_red (
      .clock     (clock),
      .adv       (adv),
      .p         (s3_p_ff),
      .q         (s3_q_ff),
      .d         (s3_d_ff),
      .ctl       (s3_ctl_ff[0]),
      .chan_byte (red)
   );

   hsl2rgb_channel u_green (
      .clock     (clock),
      .adv       (adv),
      .p         (s3_p_ff),
      .q         (s3_q_ff),
      .d         (s3_d_ff),
      .ctl       (s3_ctl_ff[1]),
      .chan_byte (green)
   );

   hsl2rgb_channel u_blue (
      .clock     (clock),
      .adv       (adv),
      .p         (s3_p_ff),
      .q         (s3_q_ff),
      .d         (s3_d_ff),
      .ctl       (s3_ctl_ff[2]),
      .chan_byte (blue)
   );

   assign rsp_tvalid = valid_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {blue, green, red};

endmodule

// ===== rtl/core/hsl2rgb_checker.sv =====
// ============================================================================
// HSL to RGB converter checker
// Port-level assertions on the converter's handshakes, bound to the top level.
// ============================================================================
module hsl2rgb_checker import hsl2rgb_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [IN_DATA_W-1:0]  req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata
);

   // A stalled request transaction stays offered with the same colour.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request withdrawn or changed while stalled");

   // A stalled result transaction stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its colour.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // With the output free the converter must be able to take a colour.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input held off with room in the pipeline");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/hsl_to_rgb_converter_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// HSL to RGB converter testbench
// Drives HSL colours into the converter stream, predicts each RGB result in
// 64-bit integer arithmetic and checks every returned transaction in order,
// under several mixes of sender idling and receiver back-pressure.
// ============================================================================
module hsl_to_rgb_converter_test;
   import hsl2rgb_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_COLOURS   = 500;
   localparam int NUM_DIRECTED    = 25;

   // Hue, saturation and lightness for the directed colours.
   localparam int DIRECTED_HSL [NUM_DIRECTED][3] = '{
      '{0, 0, 0},     '{0, 0, 100},   '{0, 0, 50},    '{0, 100, 50},
      '{120, 100, 50}, '{240, 100, 50}, '{360, 100, 50}, '{59, 100, 50},
      '{60, 100, 50},  '{179, 100, 50}, '{180, 100, 50}, '{239, 100, 50},
      '{300, 100, 50}, '{359, 100, 49}, '{200, 50, 49},  '{200, 50, 50},
      '{30, 100, 100}, '{30, 100, 0},   '{511, 127, 127}, '{361, 101, 101},
      '{400, 0, 127},  '{90, 1, 1},     '{270, 99, 99},  '{119, 37, 63},
      '{121, 63, 37}
   };

   typedef struct packed {
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
   } rgb_type;

   class rgb_scoreboard;
      rgb_type rgb_due[$];
      int      mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Level along the hue ramp between p and q at a position in degrees.
      function longint unsigned ramp_level(longint unsigned p, longint unsigned q,
                                           longint unsigned deg);
         longint unsigned span;
         span = q - p;
         if (deg < 60)
            return p + (span * deg) / 60;
         if (deg < 180)
            return q;
         if (deg < 240)
            return p + (span * (240 - deg)) / 60;
         return p;
      endfunction

      function logic [BYTE_W-1:0] level_byte(longint unsigned v);
         longint unsigned c;
         c = (v * 255) >> FRAC_BITS;
         if (c > 255)
            c = 255;
         return c[BYTE_W-1:0];
      endfunction

      function rgb_type rgb_of_hsl(logic [HUE_W-1:0] hue_in, logic [PCT_W-1:0] sat_in,
                                   logic [PCT_W-1:0] lig_in);
         longint unsigned one_level, hue, sat, lig, l, s, ls, q, p, deg_r, deg_b;
         rgb_type         rgb;
         one_level = 64'd1 << FRAC_BITS;
         hue = (hue_in > 360) ? 360 : hue_in;
         sat = (sat_in > 100) ? 100 : sat_in;
         lig = (lig_in > 100) ? 100 : lig_in;
         l = (lig * one_level) / 100;
         s = (sat * one_level) / 100;
         if (sat == 0) begin
            rgb.red   = level_byte(l);
            rgb.green = rgb.red;
            rgb.blue  = rgb.red;
         end else begin
            ls = (l * s) >> FRAC_BITS;
            q  = (lig < 50) ? l + ls : l + s - ls;
            if (q > one_level)
               q = one_level;
            // Truncation can leave 2l slightly below q; p is then held at zero.
            p = (2 * l >= q) ? 2 * l - q : 0;
            if (p > q)
               p = q;
            deg_r = hue + 120;
            if (deg_r > 360)
               deg_r -= 360;
            deg_b = (hue >= 120) ? hue - 120 : hue + 240;
            rgb.red   = level_byte(ramp_level(p, q, deg_r));
            rgb.green = level_byte(ramp_level(p, q, hue));
            rgb.blue  = level_byte(ramp_level(p, q, deg_b));
         end
         return rgb;
      endfunction

      function void note_colour(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                logic [PCT_W-1:0] lig);
         rgb_due.push_back(rgb_of_hsl(hue, sat, lig));
      endfunction

      function void check_rgb(logic [OUT_DATA_W-1:0] data);
         rgb_type want;
         string   chan_name [3];
         chan_name = '{"red", "green", "blue"};
         if (rgb_due.size() == 0) begin
            $display("%0t: unexpected result %h, nothing outstanding", $time, data);
            mismatches++;
            return;
         end
         want = rgb_due.pop_front();
         for (int c = 0; c < 3; c++) begin
            if (data[c*BYTE_W +: BYTE_W] !== want[c*BYTE_W +: BYTE_W]) begin
               $display("%0t: %s expected %h, actual %h", $time, chan_name[c],
                        want[c*BYTE_W +: BYTE_W], data[c*BYTE_W +: BYTE_W]);
               mismatches++;
            end
         end
      endfunction

      function int outstanding();
         return rgb_due.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [8:0] hue, [15:9] saturation, [22:16] lightness, [23] zero
   logic [IN_DATA_W-1:0]  req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [7:0] red, [15:8] green, [23:16] blue
   logic [OUT_DATA_W-1:0] rsp_tdata;

   int unsigned   sender_idle_pct    = 0;
   int unsigned   receiver_stall_pct = 0;
   bit            hold_off_due       = 1'b0;
   rgb_scoreboard rgb_book           = new();

   hsl_to_rgb_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         rgb_book.note_colour(req_tdata[8:0], req_tdata[15:9], req_tdata[22:16]);
      if (!reset && rsp_tvalid && rsp_tready)
         rgb_book.check_rgb(rsp_tdata);
   end

   // Result side: random stalls, plus one long hold-off on request so that the
   // pipeline fills and the input side is pushed back.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      int quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic send_colour(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                              input logic [PCT_W-1:0] lig);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, lig, sat, hue};
      do @(posedge clock); while (!req_tready);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Mostly in-range colours with some grey; a fifth use every input bit so
   // that the clamping is exercised.
   task automatic send_random_colour();
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] sat;
      logic [PCT_W-1:0] lig;
      if ($urandom_range(9) < 2) begin
         hue = HUE_W'($urandom_range(511));
         sat = PCT_W'($urandom_range(127));
         lig = PCT_W'($urandom_range(127));
      end else begin
         hue = HUE_W'($urandom_range(360));
         sat = ($urandom_range(9) == 0) ? '0 : PCT_W'($urandom_range(100));
         lig = PCT_W'($urandom_range(100));
      end
      send_colour(hue, sat, lig);
   endtask

   initial begin
      do @(posedge clock); while (reset);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_colour(HUE_W'(DIRECTED_HSL[i][0]), PCT_W'(DIRECTED_HSL[i][1]),
                     PCT_W'(DIRECTED_HSL[i][2]));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
               hold_off_due       = 1'b1;
            end
            1: begin
               sender_idle_pct    = 64;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 64;
            end
            default: begin
               sender_idle_pct    = 31;
               receiver_stall_pct = 31;
            end
         endcase
         for (int n = 0; n < PHASE_COLOURS; n++)
            send_random_colour();
      end
      req_tvalid <= 1'b0;

      while (rgb_book.outstanding() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);

      if (rgb_book.mismatches == 0 && rgb_book.outstanding() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
